// ===== design/ddw_pkg.sv =====
// shared types, constants and the shift-and-add-3 step for the digit display writer
package ddw_pkg;

  localparam int unsigned VALUE_W    = 27;
  localparam int unsigned MAX_DIGITS = 8;
  localparam int unsigned CODE_W     = 4;
  localparam int unsigned ADDR_W     = 4;
  localparam int unsigned BCD_W      = MAX_DIGITS * CODE_W;
  localparam int unsigned IN_DATA_W  = 32;
  localparam int unsigned OUT_DATA_W = 8;

  localparam logic [CODE_W-1:0] BLANK_CODE = 4'hF;
  localparam logic [CODE_W-1:0] ADJ_LIMIT  = 4'd5;
  localparam logic [CODE_W-1:0] ADJ_ADD    = 4'd3;

  // work word carried down the conversion pipeline
  typedef struct packed {
    logic [BCD_W-1:0]   bcd;
    logic [VALUE_W-1:0] bin;
  } ddw_work_t;

  typedef logic [MAX_DIGITS-1:0][CODE_W-1:0] ddw_codes_t;

  // one double-dabble step: correct every digit, then shift in the next binary bit;
  // the carry out of the top digit is dropped, which keeps the value modulo 10^8
  function automatic ddw_work_t dabble_step(input ddw_work_t w);
    ddw_work_t r;
    r = w;
    for (int d = 0; d < MAX_DIGITS; d++) begin
      if (r.bcd[d*CODE_W +: CODE_W] >= ADJ_LIMIT) begin
        r.bcd[d*CODE_W +: CODE_W] = r.bcd[d*CODE_W +: CODE_W] + ADJ_ADD;
      end
    end
    r.bcd = {r.bcd[BCD_W-2:0], r.bin[VALUE_W-1]};
    r.bin = {r.bin[VALUE_W-2:0], 1'b0};
    return r;
  endfunction

endpackage

// ===== design/decimal_digit_display_writer.sv =====
// top level: binary to bcd pipeline, leading zero blanking and digit write sequencer
//
// Each accepted number gives DIGIT_COUNT digit writes, address DIGIT_COUNT down to
// address 1, one write per cycle while the output is ready; the last write carries
// tlast; the next number is taken in the cycle its predecessor's last write leaves.
// Conversion runs through four shift-and-add-3 stages (27 steps), then one blanking
// stage. Only the value modulo 10^DIGIT_COUNT is shown, leading zeros are written as
// code 15, and address 1 always shows its digit. A DIGIT_COUNT below 1 acts as 1 and
// one above 8 acts as 8.
module decimal_digit_display_writer #(
  parameter int unsigned DIGIT_COUNT = 8
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid_i,
  output logic                              s_axis_tready_o,
  input  logic [ddw_pkg::IN_DATA_W-1:0]     s_axis_tdata_i,   // [26:0] value
  output logic                              m_axis_tvalid_o,
  input  logic                              m_axis_tready_i,
  output logic [ddw_pkg::OUT_DATA_W-1:0]    m_axis_tdata_o,   // [3:0] digit_address,
                                                              // [7:4] digit_code
  output logic                              m_axis_tlast_o    // last_write
);
  import ddw_pkg::*;

  localparam int unsigned STAGES = 4;

  // positions actually driven, clamped to what the display has
  localparam int unsigned POSITIONS =
    (DIGIT_COUNT < 1) ? 1 : ((DIGIT_COUNT > MAX_DIGITS) ? MAX_DIGITS : DIGIT_COUNT);

  logic      [STAGES:0] st_valid;
  logic      [STAGES:0] st_ready;
  ddw_work_t            st_work [STAGES+1];

  // input word enters the first conversion stage
  assign st_valid[0]     = s_axis_tvalid_i;
  assign s_axis_tready_o = st_ready[0];
  assign st_work[0].bcd  = '0;
  assign st_work[0].bin  = s_axis_tdata_i[VALUE_W-1:0];

  // conversion stages, 7 + 7 + 7 + 6 steps
  ddw_dabble_stage #(.STEPS(7)) u_stage0 (
    .clk_i, .rst_ni,
    .in_valid_i (st_valid[0]), .in_ready_o (st_ready[0]), .in_work_i (st_work[0]),
    .out_valid_o(st_valid[1]), .out_ready_i(st_ready[1]), .out_work_o(st_work[1])
  );
  ddw_dabble_stage #(.STEPS(7)) u_stage1 (
    .clk_i, .rst_ni,
    .in_valid_i (st_valid[1]), .in_ready_o (st_ready[1]), .in_work_i (st_work[1]),
    .out_valid_o(st_valid[2]), .out_ready_i(st_ready[2]), .out_work_o(st_work[2])
  );
  ddw_dabble_stage #(.STEPS(7)) u_stage2 (
    .clk_i, .rst_ni,
    .in_valid_i (st_valid[2]), .in_ready_o (st_ready[2]), .in_work_i (st_work[2]),
    .out_valid_o(st_valid[3]), .out_ready_i(st_ready[3]), .out_work_o(st_work[3])
  );
  ddw_dabble_stage #(.STEPS(6)) u_stage3 (
    .clk_i, .rst_ni,
    .in_valid_i (st_valid[3]), .in_ready_o (st_ready[3]), .in_work_i (st_work[3]),
    .out_valid_o(st_valid[4]), .out_ready_i(st_ready[4]), .out_work_o(st_work[4])
  );

  // leading zero blanking, from the top shown position down
  ddw_codes_t codes_d, codes_q;
  logic       shown;
  logic       blank_valid_q;
  logic       ser_load_ready;

  always_comb begin
    codes_d = {MAX_DIGITS{BLANK_CODE}};
    shown   = 1'b0;
    for (int i = POSITIONS - 1; i >= 0; i--) begin
      if (st_work[4].bcd[i*CODE_W +: CODE_W] != '0 || i == 0) begin
        shown = 1'b1;
      end
      if (shown) begin
        codes_d[i] = st_work[4].bcd[i*CODE_W +: CODE_W];
      end
    end
  end

  assign st_ready[4] = !blank_valid_q || ser_load_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      blank_valid_q <= 1'b0;
    end else if (st_ready[4]) begin
      blank_valid_q <= st_valid[4];
    end
  end

  always_ff @(posedge clk_i) begin
    if (st_valid[4] && st_ready[4]) begin
      codes_q <= codes_d;
    end
  end

  // write sequencer: current code sits at the head of a shift line
  logic                  busy_q;
  logic [ADDR_W-1:0]     pos_q;
  logic [CODE_W-1:0]     line_q [POSITIONS];
  logic                  word_taken;
  logic                  last_word;
  logic                  load;

  assign last_word      = (pos_q == ADDR_W'(1));
  assign word_taken     = busy_q && m_axis_tready_i;
  assign ser_load_ready = !busy_q || (word_taken && last_word);
  assign load           = blank_valid_q && ser_load_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      pos_q  <= '0;
    end else if (load) begin
      busy_q <= 1'b1;
      pos_q  <= ADDR_W'(POSITIONS);
    end else if (word_taken) begin
      busy_q <= !last_word;
      pos_q  <= pos_q - ADDR_W'(1);
    end
  end

  // codes in order of output, most significant position first
  always_ff @(posedge clk_i) begin
    if (load) begin
      for (int i = 0; i < POSITIONS; i++) begin
        line_q[i] <= codes_q[POSITIONS - 1 - i];
      end
    end else if (word_taken) begin
      for (int i = 0; i < POSITIONS - 1; i++) begin
        line_q[i] <= line_q[i+1];
      end
    end
  end

  // output word
  assign m_axis_tvalid_o = busy_q;
  assign m_axis_tdata_o  = {line_q[0], pos_q};
  assign m_axis_tlast_o  = last_word;

endmodule

// ===== design/ddw_dabble_stage.sv =====
// one register stage of the binary to bcd conversion, STEPS dabble steps deep
module ddw_dabble_stage #(
  parameter int unsigned STEPS = 7
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  ddw_pkg::ddw_work_t in_work_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output ddw_pkg::ddw_work_t out_work_o
);
  import ddw_pkg::*;

  logic      valid_q;
  ddw_work_t work_d, work_q;

  // run the steps of this stage
  always_comb begin
    work_d = in_work_i;
    for (int s = 0; s < STEPS; s++) begin
      work_d = dabble_step(work_d);
    end
  end

  assign in_ready_o = !valid_q || out_ready_i;

  // valid bit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      work_q <= work_d;
    end
  end

  assign out_valid_o = valid_q;
  assign out_work_o  = work_q;

endmodule
